// File: rtl/bfwa_pkg.sv
// ----------------------------------------------------------------------------
// bfwa_pkg
// Shared constants, types and helpers for the bit field word aligner.
// ----------------------------------------------------------------------------
`default_nettype none

package bfwa_pkg;

    // Word and register widths
    localparam int WORD_W          = 32;
    localparam int SHIFT_W         = 5;
    localparam int FIELD_LEN_W     = 10;
    localparam int CFG_INDEX_W     = 3;
    localparam int MAX_FIELD_BITS_DEF = 512;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_DIRECTION      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BIT_SHIFT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FIELD_LENGTH   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_DST_WORD = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_DST_WORD  = 3'd4;

    // Direction codes
    localparam logic DIR_INSERT  = 1'b0;
    localparam logic DIR_EXTRACT = 1'b1;

    // One destination word as held in the output queue
    typedef struct packed {
        logic [WORD_W-1:0] dst_word;
        logic              last_word;
    } out_entry_t;

    // Mask of the n low bits, all ones from 32 upwards
    function automatic logic [WORD_W-1:0] low_mask(input logic [5:0] n);
        logic [WORD_W-1:0] m;
        if (n >= 6'd32)
        begin
            m = '1;
        end
        else
        begin
            m = (32'd1 << n[4:0]) - 32'd1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bit_field_word_aligner.sv
// ----------------------------------------------------------------------------
// bit_field_word_aligner
// Funnel-shift copy of a bit field between two 32-bit word streams.
// ----------------------------------------------------------------------------
// Output: a destination word enters the output queue when the source word
// that completes it is accepted, and is offered once it heads the queue.
// Throughput: one source word per cycle while in_stall is low; shift and
// merge sit between the carry register and a four-entry output queue, which
// may take two words. Reset: registers return to their defaults, the
// transfer goes idle and the output queue empties.
`default_nettype none

module bit_field_word_aligner #(
    parameter int MAX_FIELD_BITS = bfwa_pkg::MAX_FIELD_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [bfwa_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [bfwa_pkg::WORD_W-1:0]          cfg_data,
    // source word channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [bfwa_pkg::WORD_W-1:0]          src_word,
    // destination word channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [bfwa_pkg::WORD_W-1:0]               dst_word,
    output logic                                      last_word
);

    localparam int W      = bfwa_pkg::WORD_W;
    localparam int LEN_W  = $clog2(MAX_FIELD_BITS + W) + 1;
    localparam int SAT_W  = ((LEN_W > bfwa_pkg::FIELD_LEN_W) ? LEN_W
                                                             : bfwa_pkg::FIELD_LEN_W) + 1;
    localparam int Q_DEPTH = 4;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int CNT_W   = PTR_W + 1;

    // configuration registers
    logic                                 direction_reg;
    logic [bfwa_pkg::SHIFT_W-1:0]         bit_shift_reg;
    logic [bfwa_pkg::FIELD_LEN_W-1:0]     field_length_reg;
    logic [W-1:0]                         first_dst_word_reg;
    logic [W-1:0]                         last_dst_word_reg;

    // transfer state
    logic [W-1:0]      carry_bits_reg, carry_bits_next;
    logic [LEN_W-1:0]  bits_left_reg, bits_left_next;
    logic              have_previous_reg, have_previous_next;

    // output queue
    bfwa_pkg::out_entry_t queue_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              cfg_write;
    logic              in_accept;
    logic              out_accept;
    logic              push0, push1;
    bfwa_pkg::out_entry_t entry0, entry1;

    // handshakes
    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready &&
                        (cfg_index == bfwa_pkg::REG_DIRECTION ||
                         cfg_index == bfwa_pkg::REG_BIT_SHIFT ||
                         cfg_index == bfwa_pkg::REG_FIELD_LENGTH ||
                         cfg_index == bfwa_pkg::REG_FIRST_DST_WORD ||
                         cfg_index == bfwa_pkg::REG_LAST_DST_WORD);
    assign in_stall   = (count_reg > CNT_W'(Q_DEPTH - 2));
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = (count_reg != '0);
    assign out_accept = out_valid && !out_stall;
    assign dst_word   = queue_reg[rd_ptr_reg].dst_word;
    assign last_word  = queue_reg[rd_ptr_reg].last_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg      <= bfwa_pkg::DIR_INSERT;
            bit_shift_reg      <= '0;
            field_length_reg   <= bfwa_pkg::FIELD_LEN_W'(1);
            first_dst_word_reg <= '0;
            last_dst_word_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                bfwa_pkg::REG_DIRECTION:      direction_reg      <= cfg_data[0];
                bfwa_pkg::REG_BIT_SHIFT:      bit_shift_reg      <= cfg_data[4:0];
                bfwa_pkg::REG_FIELD_LENGTH:   field_length_reg   <= cfg_data[9:0];
                bfwa_pkg::REG_FIRST_DST_WORD: first_dst_word_reg <= cfg_data;
                bfwa_pkg::REG_LAST_DST_WORD:  last_dst_word_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // shift, merge and next state for one source word
    always_comb
    begin
        logic [SAT_W-1:0]  len_sat;
        logic [LEN_W-1:0]  eff_len;
        logic [LEN_W-1:0]  span;
        logic [LEN_W-1:0]  sh_ext;
        logic              prev;
        logic [W-1:0]      carry;
        logic [W-1:0]      s_m;
        logic [W-1:0]      base;
        logic [2*W-1:0]    ins_wide;
        logic [2*W-1:0]    ext_wide;
        logic [W-1:0]      s_shr;
        logic [W-1:0]      mask;
        logic [5:0]        tail_bits;

        // effective length: zero counts as one, large values saturate
        len_sat = SAT_W'(field_length_reg);
        if (len_sat == '0)
        begin
            len_sat = SAT_W'(1);
        end
        if (len_sat > SAT_W'(MAX_FIELD_BITS))
        begin
            len_sat = SAT_W'(MAX_FIELD_BITS);
        end
        eff_len = len_sat[LEN_W-1:0];
        sh_ext  = LEN_W'(bit_shift_reg);

        // a transfer starts on a word taken while idle
        if (bits_left_reg == '0)
        begin
            prev  = 1'b0;
            carry = '0;
            span  = (direction_reg == bfwa_pkg::DIR_EXTRACT) ? (sh_ext + eff_len) : eff_len;
        end
        else
        begin
            prev  = have_previous_reg;
            carry = carry_bits_reg;
            span  = bits_left_reg;
        end

        carry_bits_next    = carry_bits_reg;
        bits_left_next     = bits_left_reg;
        have_previous_next = have_previous_reg;
        push0  = 1'b0;
        push1  = 1'b0;
        mask   = '0;
        entry0 = '{dst_word: '0, last_word: 1'b0};
        entry1 = '{dst_word: '0, last_word: 1'b0};

        // insert datapath
        s_m = src_word;
        if (span < LEN_W'(W))
        begin
            s_m = src_word & bfwa_pkg::low_mask(span[5:0]);
        end
        base     = prev ? carry : ((bit_shift_reg != '0) ? first_dst_word_reg : '0);
        ins_wide = {{W{1'b0}}, s_m} << bit_shift_reg;

        // extract datapath
        ext_wide  = {src_word, carry} >> bit_shift_reg;
        s_shr     = src_word >> bit_shift_reg;
        tail_bits = 6'(span - sh_ext);

        if (in_accept)
        begin
            case (direction_reg)
                bfwa_pkg::DIR_INSERT:
                begin
                    push0 = 1'b1;
                    entry0.dst_word = base | ins_wide[W-1:0];
                    if (span <= LEN_W'(W))
                    begin
                        // final source word, spill may need its own word
                        push1 = (sh_ext + span) > LEN_W'(W);
                        entry0.last_word = !push1;
                        entry1 = '{dst_word: ins_wide[2*W-1:W], last_word: 1'b1};
                        carry_bits_next    = '0;
                        bits_left_next     = '0;
                        have_previous_next = 1'b0;
                    end
                    else
                    begin
                        carry_bits_next    = ins_wide[2*W-1:W];
                        bits_left_next     = span - LEN_W'(W);
                        have_previous_next = 1'b1;
                    end
                end
                default:
                begin
                    if (!prev)
                    begin
                        if (span <= LEN_W'(W))
                        begin
                            mask = bfwa_pkg::low_mask(tail_bits);
                            push0  = 1'b1;
                            entry0 = '{dst_word: (last_dst_word_reg & ~mask) | (s_shr & mask),
                                       last_word: 1'b1};
                            carry_bits_next    = '0;
                            bits_left_next     = '0;
                            have_previous_next = 1'b0;
                        end
                        else
                        begin
                            carry_bits_next    = src_word;
                            bits_left_next     = span - LEN_W'(W);
                            have_previous_next = 1'b1;
                        end
                    end
                    else if (span <= sh_ext)
                    begin
                        // the joined word is the final one
                        mask = bfwa_pkg::low_mask(6'(span + LEN_W'(W) - sh_ext));
                        push0  = 1'b1;
                        entry0 = '{dst_word: (last_dst_word_reg & ~mask)
                                             | (ext_wide[W-1:0] & mask),
                                   last_word: 1'b1};
                        carry_bits_next    = '0;
                        bits_left_next     = '0;
                        have_previous_next = 1'b0;
                    end
                    else
                    begin
                        push0  = 1'b1;
                        entry0 = '{dst_word: ext_wide[W-1:0], last_word: 1'b0};
                        if (span <= LEN_W'(W))
                        begin
                            mask = bfwa_pkg::low_mask(tail_bits);
                            push1  = 1'b1;
                            entry1 = '{dst_word: (last_dst_word_reg & ~mask) | (s_shr & mask),
                                       last_word: 1'b1};
                            carry_bits_next    = '0;
                            bits_left_next     = '0;
                            have_previous_next = 1'b0;
                        end
                        else
                        begin
                            carry_bits_next = src_word;
                            bits_left_next  = span - LEN_W'(W);
                        end
                    end
                end
            endcase
        end
    end

    // transfer state; a register write drops any transfer in progress
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_bits_reg    <= '0;
            bits_left_reg     <= '0;
            have_previous_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            carry_bits_reg    <= '0;
            bits_left_reg     <= '0;
            have_previous_reg <= 1'b0;
        end
        else
        begin
            carry_bits_reg    <= carry_bits_next;
            bits_left_reg     <= bits_left_next;
            have_previous_reg <= have_previous_next;
        end
    end

    // output queue storage
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            queue_reg[wr_ptr_reg] <= entry0;
        end
        if (push1)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= entry1;
        end
    end

    // output queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push0) + PTR_W'(push1);
            rd_ptr_reg <= rd_ptr_reg + PTR_W'(out_accept);
            count_reg  <= count_reg + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(out_accept);
        end
    end

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("output queue count beyond depth");

    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_left_reg <= LEN_W'(MAX_FIELD_BITS + W - 1))
        else $error("remaining span beyond largest field");

    a_prev_busy: assert property (@(posedge clk) disable iff (!rst_n)
        have_previous_reg |-> (bits_left_reg != '0))
        else $error("carry marked valid while idle");

    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (push0 && entry0.last_word) || push1 |=> (bits_left_reg == '0))
        else $error("transfer not idle after its final word");

endmodule

`default_nettype wire
